FILE: rtl/core/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, types and register codes of the masked byte pattern search.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int WIN_DEPTH   = PATTERN_MAX - 1;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int ADDR_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int REG_PAT_BYTES = 16;

	typedef logic [7:0] byte_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3,
		REG_IMAGE_BASE   = 3'd4,
		REG_IMAGE_SIZE   = 3'd5
	} cfg_reg_e;

	// pattern reversed against the window: entry j faces the byte j places back
	typedef struct packed {
		logic [PATTERN_MAX-1:0][7:0] apat;
		logic [PATTERN_MAX-1:0]      acare;
		logic [LEN_W-1:0]            len_m1;
		addr_t                       size_m1;
		addr_t                       addr_base;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/mbps_ifs.sv
// ----------------------------------------------------------------------------
// mbps channel interfaces
// Valid/ready channels for image bytes, search results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_byte_if;
	import mbps_pkg::*;
	logic  valid;
	logic  ready;
	byte_t mem_byte;
	logic  scan_start;
	modport source (output valid, output mem_byte, output scan_start, input ready);
	modport sink (input valid, input mem_byte, input scan_start, output ready);
endinterface

interface mbps_result_if;
	import mbps_pkg::*;
	logic  valid;
	logic  ready;
	logic  found;
	addr_t match_address;
	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

interface mbps_cfg_if;
	import mbps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration registers and a registered copy of the pattern aligned to
// the byte window by the effective length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	mbps_cfg_if.sink           cfg,
	output mbps_pkg::cfg_t     cfg_s
);
	import mbps_pkg::*;

	logic [63:0] pat_lo_q;
	logic [63:0] pat_hi_q;
	logic [15:0] care_q;
	logic [4:0]  len_q;
	addr_t       base_q;
	addr_t       size_q;
	cfg_t        cfg_d;
	cfg_t        cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			len_q    <= 5'd1;
			base_q   <= '0;
			size_q   <= addr_t'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PATTERN_LOW:  pat_lo_q <= cfg.data;
				REG_PATTERN_HIGH: pat_hi_q <= cfg.data;
				REG_CARE_MASK:    care_q   <= cfg.data[15:0];
				REG_PATTERN_LEN:  len_q    <= cfg.data[4:0];
				REG_IMAGE_BASE:   base_q   <= cfg.data[ADDR_W-1:0];
				REG_IMAGE_SIZE:   size_q   <= cfg.data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [PATTERN_MAX-1:0][7:0] pat;
		logic [PATTERN_MAX-1:0]      care;
		logic [127:0]                pat_all;
		int                          l;
		pat_all = {pat_hi_q, pat_lo_q};
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (i < REG_PAT_BYTES) begin
				pat[i]  = pat_all[8*(i%REG_PAT_BYTES) +: 8];
				care[i] = care_q[i%REG_PAT_BYTES];
			end else begin
				pat[i]  = '0;
				care[i] = 1'b0;
			end
		end
		// zero acts as one, too long saturates
		l = int'(len_q);
		if (l == 0) begin
			l = 1;
		end
		if (l > PATTERN_MAX) begin
			l = PATTERN_MAX;
		end
		cfg_d.apat  = '0;
		cfg_d.acare = '0;
		for (int n = 1; n <= PATTERN_MAX; n++) begin
			if (l == n) begin
				for (int j = 0; j < n; j++) begin
					cfg_d.apat[j]  = pat[n-1-j];
					cfg_d.acare[j] = care[n-1-j];
				end
			end
		end
		cfg_d.len_m1    = LEN_W'(l - 1);
		cfg_d.size_m1   = (size_q == '0) ? '0 : size_q - addr_t'(1);
		cfg_d.addr_base = base_q - addr_t'(cfg_d.len_m1);
	end

	always_ff @(posedge clk) begin
		cfg_q <= cfg_d;
	end

	assign cfg_s = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/mbps_match.sv
// ----------------------------------------------------------------------------
// mbps_match
// Parallel masked compare of the aligned pattern against the current byte
// and the byte window.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_match (
	input  mbps_pkg::byte_t                          cur_byte,
	input  logic [mbps_pkg::WIN_DEPTH-1:0][7:0]      win,
	input  mbps_pkg::addr_t                          pos,
	input  mbps_pkg::cfg_t                           cfg_s,
	output logic                                     match
);
	import mbps_pkg::*;

	logic [PATTERN_MAX-1:0][7:0] seq;
	logic [PATTERN_MAX-1:0]      ok;

	always_comb begin
		seq[0] = cur_byte;
		for (int j = 1; j < PATTERN_MAX; j++) begin
			seq[j] = win[j-1];
		end
		for (int j = 0; j < PATTERN_MAX; j++) begin
			ok[j] = !cfg_s.acare[j] || (cfg_s.apat[j] == seq[j]);
		end
	end

	// enough bytes seen for the whole pattern
	assign match = (pos >= addr_t'(cfg_s.len_m1)) && (&ok);

endmodule

`default_nettype wire

FILE: rtl/core/mbps_scan_core.sv
// ----------------------------------------------------------------------------
// mbps_scan_core
// Input register, byte window and position state, match evaluation and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_scan_core (
	input  logic               clk,
	input  logic               arst_n,
	input  mbps_pkg::cfg_t     cfg_s,
	mbps_byte_if.sink          scan,
	mbps_result_if.source      result
);
	import mbps_pkg::*;

	logic                    v_s1;
	byte_t                   byte_s1;
	logic                    start_s1;
	logic [WIN_DEPTH-1:0][7:0] win_q;
	addr_t                   pos_q;
	logic                    fin_q;
	logic                    out_v_q;
	logic                    found_q;
	addr_t                   addr_q;

	logic                    advance;
	logic [WIN_DEPTH-1:0][7:0] win_eff;
	logic [WIN_DEPTH-1:0][7:0] win_nxt;
	addr_t                   pos_eff;
	logic                    fin_eff;
	logic                    match;
	logic                    last;

	assign advance    = v_s1 && (!out_v_q || result.ready);
	assign scan.ready = !v_s1 || advance;

	assign win_eff = start_s1 ? '0 : win_q;
	assign pos_eff = start_s1 ? '0 : pos_q;
	assign fin_eff = start_s1 ? 1'b0 : fin_q;
	assign last    = pos_eff >= cfg_s.size_m1;

	always_comb begin
		win_nxt[0] = byte_s1;
		for (int j = 1; j < WIN_DEPTH; j++) begin
			win_nxt[j] = win_eff[j-1];
		end
	end

	mbps_match u_match (
		.cur_byte (byte_s1),
		.win      (win_eff),
		.pos      (pos_eff),
		.cfg_s    (cfg_s),
		.match    (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (scan.ready) begin
			v_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			byte_s1  <= scan.mem_byte;
			start_s1 <= scan.scan_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			pos_q   <= '0;
			fin_q   <= 1'b1;
			out_v_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_v_q <= 1'b0;
			end
			if (advance && !fin_eff) begin
				win_q <= win_nxt;
				if (match || last) begin
					fin_q   <= 1'b1;
					pos_q   <= pos_eff;
					out_v_q <= 1'b1;
				end else begin
					fin_q <= 1'b0;
					pos_q <= pos_eff + addr_t'(1);
				end
			end
		end
	end

	// match wins over end of image
	always_ff @(posedge clk) begin
		if (advance && !fin_eff && (match || last)) begin
			found_q <= match;
			addr_q  <= match ? cfg_s.addr_base + pos_eff : '0;
		end
	end

	assign result.valid         = out_v_q;
	assign result.found         = found_q;
	assign result.match_address = addr_q;

endmodule

`default_nettype wire

FILE: rtl/core/masked_byte_pattern_search_top.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top
// Finds the first position of a masked byte pattern in a streamed image.
//
//   channel  dir  payload                          accept
//   scan     in   mem_byte[7:0], scan_start        valid && ready
//   result   out  found, match_address[31:0]       valid && ready
//   cfg      in   index[2:0], data[63:0]           valid && ready
//
// One byte per cycle sustained while the result is not stalled; a byte passes the
// input register, then the compare and state update into the result register.
// The compare of all window positions is combinational and done in parallel.
// Reset: no scan active, registers at their defaults; a config write passes the
// config registers, then the registered aligned pattern copy.
// A stalled result holds one byte in the input register, then scan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_search_top (
	input  logic           clk,
	input  logic           arst_n,
	mbps_byte_if.sink      scan,
	mbps_result_if.source  result,
	mbps_cfg_if.sink       cfg
);
	import mbps_pkg::*;

	cfg_t cfg_s;

	mbps_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_s  (cfg_s)
	);

	mbps_scan_core u_scan_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_s  (cfg_s),
		.scan   (scan),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: rtl/core/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the masked byte pattern search, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   scan_valid,
	input  logic                   scan_ready,
	input  logic                   scan_start,
	input  logic                   res_valid,
	input  logic                   res_ready,
	input  logic                   res_found,
	input  mbps_pkg::addr_t        res_address
);
	import mbps_pkg::*;

	logic armed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (scan_valid && scan_ready && scan_start) begin
			armed_q <= 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_address))
		else $error("result changed while stalled");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_address == '0)
		else $error("not-found result with nonzero address");

	a_no_result_unarmed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> armed_q)
		else $error("result before any scan start");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid || res_ready |-> scan_ready)
		else $error("input stalled while output can drain");

endmodule

bind masked_byte_pattern_search_top mbps_checker u_mbps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.scan_valid  (scan.valid),
	.scan_ready  (scan.ready),
	.scan_start  (scan.scan_start),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_found   (result.found),
	.res_address (result.match_address)
);

`default_nettype wire

FILE: dv/masked_byte_pattern_search_checker.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_checker
// Watches the scan, result and register channels of the pattern search. Every
// accepted image word is run through a local search model that keeps its own
// byte history, position and register copies. Each accepted result word is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_checker (
	input  logic   clk,
	input  logic   arst_n,
	mbps_byte_if   scan,
	mbps_result_if result,
	mbps_cfg_if    cfg,
	output int     pending,
	output int     errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import mbps_pkg::*;

	typedef struct packed {
		logic  found;
		addr_t match_address;
	} search_result_t;

	logic [127:0] pattern_r;
	logic [15:0]  care_r;
	logic [4:0]   len_r;
	addr_t        base_r;
	addr_t        size_r;

	byte_t        history [WIN_DEPTH];
	logic [31:0]  offset;
	logic         done;

	search_result_t awaited_results [$];
	int             mismatches;

	assign errors = mismatches;

	function automatic byte_t pattern_at(int unsigned idx);
		return pattern_r[8*idx +: 8];
	endfunction

	function automatic bit next_search_result(input byte_t cur, input logic start,
		output search_result_t res);
		int unsigned n;
		int unsigned sz;
		int unsigned i;
		bit hit;
		res = '0;
		if (start) begin
			foreach (history[j]) history[j] = 8'h00;
			offset = '0;
			done = 1'b0;
		end
		if (done)
			return 1'b0;
		n = (len_r == 0) ? 1 : ((len_r > PATTERN_MAX) ? PATTERN_MAX : len_r);
		sz = (size_r == 0) ? 1 : size_r;
		hit = (offset >= n - 1);
		if (hit && care_r[n-1] && pattern_at(n - 1) != cur)
			hit = 1'b0;
		for (i = 0; hit && i + 1 < n; i++) begin
			if (care_r[i] && pattern_at(i) != history[n-2-i])
				hit = 1'b0;
		end
		for (i = WIN_DEPTH - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = cur;
		if (hit) begin
			done = 1'b1;
			res.found = 1'b1;
			res.match_address = base_r + (offset - (n - 1));
			return 1'b1;
		end
		if (offset >= sz - 1) begin
			done = 1'b1;
			return 1'b1;
		end
		offset = offset + 1;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		search_result_t want;
		search_result_t pred;
		if (!arst_n) begin
			pattern_r = '0;
			care_r = '0;
			len_r = 5'd1;
			base_r = '0;
			size_r = 32'd1;
			foreach (history[j]) history[j] = 8'h00;
			offset = '0;
			done = 1'b1;
			awaited_results.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result word: found %0b, match_address %h",
						result.found, result.match_address);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (result.found !== want.found) begin
						$error("found: expected %0b, actual %0b", want.found, result.found);
						mismatches++;
					end
					if (result.match_address !== want.match_address) begin
						$error("match_address: expected %h, actual %h",
							want.match_address, result.match_address);
						mismatches++;
					end
				end
			end
			if (scan.valid && scan.ready) begin
				if (next_search_result(scan.mem_byte, scan.scan_start, pred))
					awaited_results.push_back(pred);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_PATTERN_LOW:  pattern_r[63:0] = cfg.data;
					REG_PATTERN_HIGH: pattern_r[127:64] = cfg.data;
					REG_CARE_MASK:    care_r = cfg.data[15:0];
					REG_PATTERN_LEN:  len_r = cfg.data[4:0];
					REG_IMAGE_BASE:   base_r = cfg.data[31:0];
					REG_IMAGE_SIZE:   size_r = cfg.data[31:0];
					default: ;
				endcase
			end
			pending <= awaited_results.size();
		end
	end

endmodule

FILE: dv/masked_byte_pattern_search_top_tb.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top_tb
// Drives image scans into the pattern search: a short directed set for length
// and size limits, wildcards, address wrap and end of image, then random
// register settings with planted, broken and truncated patterns. Sender and
// receiver stall at random in the first two of three phases; the checker gives the verdict data.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mbps_pkg::*;

	localparam int ITEM_TARGET   = 1800;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 4000;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   items;
	int   pending;
	int   errors;
	int   stall_cycles;

	mbps_byte_if   scan_ch ();
	mbps_result_if result_ch ();
	mbps_cfg_if    cfg_ch ();

	masked_byte_pattern_search_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	masked_byte_pattern_search_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.scan    (scan_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.pending (pending),
		.errors  (errors)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((scan_ch.valid && scan_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	task automatic send_byte(input byte_t value, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			scan_ch.valid <= 1'b0;
			@(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.mem_byte <= value;
		scan_ch.scan_start <= start;
		@(posedge clk);
		while (!scan_ch.ready)
			@(posedge clk);
	endtask

	task automatic run_scan(input byte_t image[$]);
		foreach (image[i])
			send_byte(image[i], i == 0);
		items += image.size();
	endtask

	// waits for outstanding results plus pipeline drain
	task automatic settle();
		scan_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_e idx, input logic [63:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
		input logic [15:0] care, input logic [4:0] plen, input addr_t base, input addr_t size);
		settle();
		put_reg(REG_PATTERN_LOW, lo);
		put_reg(REG_PATTERN_HIGH, hi);
		put_reg(REG_CARE_MASK, 64'(care));
		put_reg(REG_PATTERN_LEN, 64'(plen));
		put_reg(REG_IMAGE_BASE, 64'(base));
		put_reg(REG_IMAGE_SIZE, 64'(size));
		cfg_ch.valid <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	task automatic random_round();
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [127:0] pat;
		logic [15:0]  care;
		logic [4:0]   plen;
		addr_t        base;
		addr_t        size;
		int unsigned  eff_size;
		int           n_len;
		int           n_send;
		int           off;
		int           pick;
		int           j;
		bit           must_hit;
		byte_t        image[$];
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		pat = {hi, lo};
		pick = $urandom_range(99);
		care = (pick < 8) ? 16'h0000 : ((pick < 20) ? 16'hFFFF : 16'($urandom));
		pick = $urandom_range(99);
		if (pick < 5)
			plen = 5'd0;
		else if (pick < 12)
			plen = 5'($urandom_range(17, 31));
		else if (pick < 20)
			plen = 5'd16;
		else if (pick < 60)
			plen = 5'($urandom_range(1, 4));
		else
			plen = 5'($urandom_range(1, 16));
		pick = $urandom_range(99);
		if (pick < 10)
			base = 32'hFFFF_FFFF - $urandom_range(0, 15);
		else if (pick < 15)
			base = '0;
		else
			base = $urandom;
		pick = $urandom_range(99);
		if (pick < 5)
			size = '0;
		else if (pick < 10)
			size = '1;
		else if (pick < 15)
			size = $urandom;
		else if (pick < 25)
			size = $urandom_range(1, 3);
		else
			size = $urandom_range(4, 40);
		configure(lo, hi, care, plen, base, size);

		n_len = (plen == 0) ? 1 : ((plen > PATTERN_MAX) ? PATTERN_MAX : plen);
		eff_size = (size == 0) ? 1 : size;
		must_hit = (eff_size > 48);
		repeat ($urandom_range(1, 4)) begin
			n_send = must_hit ? $urandom_range(n_len, 48) : int'(eff_size);
			image.delete();
			for (j = 0; j < n_send; j++)
				image.push_back($urandom_range(1) ? pat[8*$urandom_range(0, 15) +: 8] :
					8'($urandom));
			if (must_hit || $urandom_range(99) < 70) begin
				if (!must_hit && (n_send < n_len || $urandom_range(99) < 20))
					off = $urandom_range(0, n_send - 1);
				else
					off = $urandom_range(0, n_send - n_len);
				for (j = 0; j < n_len; j++)
					if (off + j < n_send && care[j])
						image[off+j] = pat[8*j +: 8];
				if (!must_hit && $urandom_range(99) < 15) begin
					j = $urandom_range(0, n_len - 1);
					if (off + j < n_send)
						image[off+j] ^= 8'($urandom_range(1, 255));
				end
			end
			// restart mid image now and then
			if ($urandom_range(99) < 10)
				image = image[0:$urandom_range(0, n_send - 1)];
			if ($urandom_range(99) < 10)
				send_byte(8'($urandom), 1'b0);
			run_scan(image);
			repeat ($urandom_range(0, 2))
				send_byte(8'($urandom), 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		items = 0;
		send_idle_pct = 29;
		recv_idle_pct = 63;
		scan_ch.valid = 1'b0;
		scan_ch.mem_byte = 8'h00;
		scan_ch.scan_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_PATTERN_LOW;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any scan start
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// defaults: one wildcard byte, image of one
		run_scan('{8'hA5});
		// zero length and zero size
		configure('1, '1, 16'h0001, 5'd0, 32'h1234_5678, 32'd0);
		run_scan('{8'hFF});
		// match on the last byte, then too few bytes left
		configure(64'h0000_0000_0000_2211, '0, 16'h0003, 5'd2, 32'h0000_0100, 32'd3);
		run_scan('{8'h00, 8'h11, 8'h22});
		run_scan('{8'h00, 8'h00, 8'h11});
		// oversized length, full care, address wrap
		configure('1, '1, 16'hFFFF, 5'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_scan('{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

		while (items < ITEM_TARGET) begin
			if (items < ITEM_TARGET / 3) begin
				send_idle_pct = 29;
				recv_idle_pct = 63;
			end else if (items < 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 63;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_round();
		end

		settle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: masked_byte_pattern_search_top.f
rtl/core/mbps_pkg.sv
rtl/core/mbps_ifs.sv
rtl/core/mbps_cfg_regs.sv
rtl/core/mbps_match.sv
rtl/core/mbps_scan_core.sv
rtl/core/masked_byte_pattern_search_top.sv
rtl/core/mbps_checker.sv
dv/masked_byte_pattern_search_checker.sv
dv/masked_byte_pattern_search_top_tb.sv
